// ----- hw/rtl/tpo_pkg.sv -----
// Shared widths, types and helpers for the triangle pair overlap unit.
// No dependencies; every other file imports this package.
package tpo_pkg;

    // Field and coordinate widths
    localparam int CW  = 20;               // coordinate slice width
    localparam int VW  = 60;               // vertex word width
    localparam int MGW = 19;               // margin register width
    localparam int XW  = (3 * CW > VW) ? 3 * CW : VW;

    // Derived arithmetic widths
    localparam int EW   = CW + 1;          // edge component
    localparam int AW   = 2 * EW + 1;      // axis component (cross product)
    localparam int PW   = CW + AW;         // vertex times axis component
    localparam int SW   = PW + 2;          // projection (sum of three)
    localparam int GW   = SW + 1;          // gap
    localparam int L2W  = 2 * AW + 2;      // squared axis length
    localparam int M2W  = 2 * MGW;         // squared margin
    localparam int GLW  = (GW - 1 < 63) ? GW - 1 : 63; // gap width that gets squared
    localparam int SQW  = 2 * GLW;
    localparam int RW   = M2W + L2W;
    localparam int CMPW = (SQW > RW) ? SQW : RW;

    // Multiplier split points
    localparam int AH  = (AW + 1) / 2;
    localparam int AHI = AW - AH;
    localparam int GH  = (GLW + 1) / 2;
    localparam int GHI = GLW - GH;
    localparam int MH  = (M2W + 1) / 2;
    localparam int MHI = M2W - MH;
    localparam int LP  = (L2W + 2) / 3;
    localparam int LC  = L2W - 2 * LP;

    // Lanes and pipeline depth
    localparam int NUM_LANES   = 11;
    localparam int LANE_STAGES = 7;
    localparam int TOP_STAGES  = LANE_STAGES + 2;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [EW-1:0] t_edge;
    typedef logic signed [AW-1:0] t_axis;
    typedef t_coord t_tri [3][3];
    typedef t_edge  t_evec [3];

    typedef struct packed {
        logic [LANE_STAGES:1] en;
    } t_lane_ctl;

    // Extract one signed slice (0 = x, 1 = y, 2 = z) of a vertex word
    function automatic t_coord get_coord(input logic [VW-1:0] word, input int slice);
        logic [XW-1:0] ext;
        ext = XW'(word);
        return t_coord'(ext[slice*CW +: CW]);
    endfunction

endpackage

// ----- hw/rtl/tpo_in_if.sv -----
// Input channel: one triangle pair per item.
// Depends on tpo_pkg for the vertex word width.
interface tpo_in_if import tpo_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [VW-1:0] a_vertex0;
    logic [VW-1:0] a_vertex1;
    logic [VW-1:0] a_vertex2;
    logic [VW-1:0] b_vertex0;
    logic [VW-1:0] b_vertex1;
    logic [VW-1:0] b_vertex2;

    modport source (output valid, output a_vertex0, output a_vertex1, output a_vertex2,
                    output b_vertex0, output b_vertex1, output b_vertex2, input ready);
    modport sink (input valid, input a_vertex0, input a_vertex1, input a_vertex2,
                  input b_vertex0, input b_vertex1, input b_vertex2, output ready);
endinterface

// ----- hw/rtl/tpo_out_if.sv -----
// Output channel: one overlap flag per item.
// Depends on tpo_pkg (imported for consistency with the input channel).
interface tpo_out_if import tpo_pkg::*; ();
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, output overlap, input ready);
    modport sink (input valid, input overlap, output ready);
endinterface

// ----- hw/rtl/tpo_front.sv -----
// Front stage: unpack the six vertices and form the edge pairs for every lane.
// Depends on tpo_pkg.
module tpo_front import tpo_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [VW-1:0] i_vtx [6],
    output t_tri          o_a,
    output t_tri          o_b,
    output t_evec         o_p [NUM_LANES],
    output t_evec         o_q [NUM_LANES]
);

    t_tri  w_a;
    t_tri  w_b;
    t_evec w_ea [3];
    t_evec w_eb [3];
    t_evec n_p [NUM_LANES];
    t_evec n_q [NUM_LANES];

    // Unpack and build edges
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                w_a[v][k] = get_coord(i_vtx[v], k);
                w_b[v][k] = get_coord(i_vtx[3 + v], k);
            end
        end
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                w_ea[v][k] = t_edge'(w_a[v][k]) - t_edge'(w_a[(v + 1) % 3][k]);
                w_eb[v][k] = t_edge'(w_b[v][k]) - t_edge'(w_b[(v + 1) % 3][k]);
            end
        end
        // Edge-edge axes
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_p[3 * i + j] = w_ea[i];
                n_q[3 * i + j] = w_eb[j];
            end
        end
        // Face normals of A and B
        for (int k = 0; k < 3; k++) begin
            n_p[9][k]  = t_edge'(w_a[1][k]) - t_edge'(w_a[0][k]);
            n_q[9][k]  = t_edge'(w_a[2][k]) - t_edge'(w_a[0][k]);
            n_p[10][k] = t_edge'(w_b[1][k]) - t_edge'(w_b[0][k]);
            n_q[10][k] = t_edge'(w_b[2][k]) - t_edge'(w_b[0][k]);
        end
    end

    // Hold results for the lanes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_a <= w_a;
            o_b <= w_b;
            o_p <= n_p;
            o_q <= n_q;
        end
    end

endmodule

// ----- hw/rtl/tpo_lane.sv -----
// One axis lane: cross product, projections, spans, gaps and the margin test.
// Depends on tpo_pkg; seven register stages, each advanced by its own enable.
module tpo_lane import tpo_pkg::*; (
    input  logic           i_clk,
    input  t_lane_ctl      i_ctl,
    input  t_evec          i_p,
    input  t_evec          i_q,
    input  t_tri           i_a,
    input  t_tri           i_b,
    input  logic [M2W-1:0] i_m2,
    output logic           o_sep
);

    // Stage 1: axis
    logic signed [2*EW-1:0] w_c0 [3];
    logic signed [2*EW-1:0] w_c1 [3];
    t_axis n_ax [3];
    t_axis r_ax [3];

    always_comb begin
        w_c0[0] = i_p[1] * i_q[2];
        w_c1[0] = i_p[2] * i_q[1];
        w_c0[1] = i_p[2] * i_q[0];
        w_c1[1] = i_p[0] * i_q[2];
        w_c0[2] = i_p[0] * i_q[1];
        w_c1[2] = i_p[1] * i_q[0];
        for (int k = 0; k < 3; k++) begin
            n_ax[k] = t_axis'(w_c0[k]) - t_axis'(w_c1[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_ax <= n_ax;
        end
    end

    // Stage 2: projection products and length partial products
    t_coord w_vtx [6][3];
    logic signed [PW-1:0] n_pr [6][3];
    logic signed [PW-1:0] r_pr [6][3];
    logic [AW-1:0]        w_mag [3];
    logic [AH-1:0]        w_mlo [3];
    logic [AHI-1:0]       w_mhi [3];
    logic [2*AH-1:0]      n_ll [3];
    logic [AH+AHI-1:0]    n_lh [3];
    logic [2*AHI-1:0]     n_hh [3];
    logic [2*AH-1:0]      r_ll [3];
    logic [AH+AHI-1:0]    r_lh [3];
    logic [2*AHI-1:0]     r_hh [3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                w_vtx[v][k]     = i_a[v][k];
                w_vtx[3 + v][k] = i_b[v][k];
            end
        end
        for (int v = 0; v < 6; v++) begin
            for (int k = 0; k < 3; k++) begin
                n_pr[v][k] = w_vtx[v][k] * r_ax[k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r_ax[k][AW-1] ? AW'(-r_ax[k]) : AW'(r_ax[k]);
            w_mlo[k] = w_mag[k][AH-1:0];
            w_mhi[k] = w_mag[k][AW-1:AH];
            n_ll[k]  = (2*AH)'(w_mlo[k]) * (2*AH)'(w_mlo[k]);
            n_lh[k]  = (AH+AHI)'(w_mlo[k]) * (AH+AHI)'(w_mhi[k]);
            n_hh[k]  = (2*AHI)'(w_mhi[k]) * (2*AHI)'(w_mhi[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_pr <= n_pr;
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hh <= n_hh;
        end
    end

    // Stage 3: projections and squared axis length
    logic signed [SW-1:0] n_proj [6];
    logic signed [SW-1:0] r_proj [6];
    logic [L2W-1:0]       n_len2;
    logic [L2W-1:0]       r_len2;

    always_comb begin
        for (int v = 0; v < 6; v++) begin
            n_proj[v] = SW'(r_pr[v][0]) + SW'(r_pr[v][1]) + SW'(r_pr[v][2]);
        end
        n_len2 = '0;
        for (int k = 0; k < 3; k++) begin
            n_len2 = n_len2 + (L2W'(r_hh[k]) << (2 * AH)) + (L2W'(r_lh[k]) << (AH + 1))
                     + L2W'(r_ll[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_proj <= n_proj;
            r_len2 <= n_len2;
        end
    end

    // Stage 4: spans and gaps
    logic signed [SW-1:0] w_mna, w_mxa, w_mnb, w_mxb;
    logic signed [GW-1:0] n_g [2];
    logic signed [GW-1:0] r_g [2];
    logic [L2W-1:0]       r_len2_4;

    always_comb begin
        w_mna = r_proj[0];
        w_mxa = r_proj[0];
        w_mnb = r_proj[3];
        w_mxb = r_proj[3];
        for (int v = 1; v < 3; v++) begin
            if (r_proj[v] < w_mna) w_mna = r_proj[v];
            if (r_proj[v] > w_mxa) w_mxa = r_proj[v];
            if (r_proj[3 + v] < w_mnb) w_mnb = r_proj[3 + v];
            if (r_proj[3 + v] > w_mxb) w_mxb = r_proj[3 + v];
        end
        n_g[0] = GW'(w_mnb) - GW'(w_mxa);
        n_g[1] = GW'(w_mna) - GW'(w_mxb);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_g      <= n_g;
            r_len2_4 <= r_len2;
        end
    end

    // Stage 5: gap classification and partial products of both squares
    logic [GLW-1:0]     w_glo [2];
    logic               n_cand [2];
    logic               n_big [2];
    logic [2*GH-1:0]    n_gll [2];
    logic [GH+GHI-1:0]  n_glh [2];
    logic [2*GHI-1:0]   n_ghh [2];
    logic [MH+LP-1:0]   n_mp [2][3];
    logic [LP-1:0]      w_lc [3];
    logic [MH-1:0]      w_mc [2];
    logic               r_cand5 [2];
    logic               r_big5 [2];
    logic [2*GH-1:0]    r_gll [2];
    logic [GH+GHI-1:0]  r_glh [2];
    logic [2*GHI-1:0]   r_ghh [2];
    logic [MH+LP-1:0]   r_mp [2][3];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_cand[i] = !r_g[i][GW-1] && (r_g[i] != '0);
            n_big[i]  = !r_g[i][GW-1] && (($unsigned(r_g[i]) >> GLW) != '0);
            w_glo[i]  = r_g[i][GLW-1:0];
            n_gll[i]  = (2*GH)'(w_glo[i][GH-1:0]) * (2*GH)'(w_glo[i][GH-1:0]);
            n_glh[i]  = (GH+GHI)'(w_glo[i][GH-1:0]) * (GH+GHI)'(w_glo[i][GLW-1:GH]);
            n_ghh[i]  = (2*GHI)'(w_glo[i][GLW-1:GH]) * (2*GHI)'(w_glo[i][GLW-1:GH]);
        end
        w_lc[0] = r_len2_4[LP-1:0];
        w_lc[1] = r_len2_4[2*LP-1:LP];
        w_lc[2] = LP'(r_len2_4[L2W-1:2*LP]);
        w_mc[0] = i_m2[MH-1:0];
        w_mc[1] = MH'(i_m2[M2W-1:MH]);
        for (int j = 0; j < 2; j++) begin
            for (int c = 0; c < 3; c++) begin
                n_mp[j][c] = (MH+LP)'(w_mc[j]) * (MH+LP)'(w_lc[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_cand5 <= n_cand;
            r_big5  <= n_big;
            r_gll   <= n_gll;
            r_glh   <= n_glh;
            r_ghh   <= n_ghh;
            r_mp    <= n_mp;
        end
    end

    // Stage 6: gap squares and margin times axis length, both squared
    logic [CMPW-1:0] n_sq [2];
    logic [CMPW-1:0] n_rhs;
    logic [CMPW-1:0] r_sq [2];
    logic [CMPW-1:0] r_rhs;
    logic            r_cand6 [2];
    logic            r_big6 [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_sq[i] = (CMPW'(r_ghh[i]) << (2 * GH)) + (CMPW'(r_glh[i]) << (GH + 1))
                      + CMPW'(r_gll[i]);
        end
        n_rhs = '0;
        for (int j = 0; j < 2; j++) begin
            for (int c = 0; c < 3; c++) begin
                n_rhs = n_rhs + (CMPW'(r_mp[j][c]) << (j * MH + c * LP));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r_sq    <= n_sq;
            r_rhs   <= n_rhs;
            r_cand6 <= r_cand5;
            r_big6  <= r_big5;
        end
    end

    // Stage 7: separation decision
    logic n_sep;

    always_comb begin
        n_sep = 1'b0;
        for (int i = 0; i < 2; i++) begin
            if (r_cand6[i] && (r_big6[i] || (r_sq[i] > r_rhs))) n_sep = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[7]) begin
            o_sep <= n_sep;
        end
    end

endmodule

// ----- hw/rtl/triangle_pair_overlap_sat_unit.sv -----
// Triangle pair overlap test: eleven axis lanes run side by side, then merge.
// Stages from item accept to result valid: front, 7 lane stages, merge.
// Throughput: one item per cycle; a full stage holds unless its successor advances.
// Reset clears all stage valid bits and the squared margin (margin reads 0).
// Depends on tpo_pkg, tpo_in_if, tpo_out_if, tpo_front and tpo_lane.
module triangle_pair_overlap_sat_unit import tpo_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tpo_in_if.sink           i_in,
    tpo_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [MGW-1:0]   i_cfg_wdata
);

    logic [TOP_STAGES:0]   w_en;
    logic [TOP_STAGES-1:0] r_v;
    logic [M2W-1:0]        r_m2;
    t_lane_ctl             w_ctl;

    // Store the squared margin on a configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2 <= '0;
        end else if (i_cfg_we) begin
            r_m2 <= M2W'(i_cfg_wdata) * M2W'(i_cfg_wdata);
        end
    end

    // Stage enables: a stage advances when empty or when its successor advances
    always_comb begin
        w_en[TOP_STAGES] = o_out.ready;
        for (int k = TOP_STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k + 1];
        end
        w_ctl.en = w_en[LANE_STAGES:1];
    end

    assign i_in.ready = w_en[0];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < TOP_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k - 1];
                end
            end
        end
    end

    // Front stage
    logic [VW-1:0] w_vtx [6];
    t_tri          w_a0, w_b0;
    t_tri          r_a1, r_b1;
    t_evec         w_p [NUM_LANES];
    t_evec         w_q [NUM_LANES];

    assign w_vtx[0] = i_in.a_vertex0;
    assign w_vtx[1] = i_in.a_vertex1;
    assign w_vtx[2] = i_in.a_vertex2;
    assign w_vtx[3] = i_in.b_vertex0;
    assign w_vtx[4] = i_in.b_vertex1;
    assign w_vtx[5] = i_in.b_vertex2;

    tpo_front u_front (
        .i_clk (i_clk),
        .i_en  (w_en[0]),
        .i_vtx (w_vtx),
        .o_a   (w_a0),
        .o_b   (w_b0),
        .o_p   (w_p),
        .o_q   (w_q)
    );

    // Keep vertices aligned with the lane axis stage
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_a1 <= w_a0;
            r_b1 <= w_b0;
        end
    end

    // Axis lanes
    logic [NUM_LANES-1:0] w_sep;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        tpo_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_p   (w_p[l]),
            .i_q   (w_q[l]),
            .i_a   (r_a1),
            .i_b   (r_b1),
            .i_m2  (r_m2),
            .o_sep (w_sep[l])
        );
    end

    // Merge: any separating axis clears the overlap flag
    logic r_overlap;

    always_ff @(posedge i_clk) begin
        if (w_en[TOP_STAGES - 1]) begin
            r_overlap <= ~|w_sep;
        end
    end

    assign o_out.valid   = r_v[TOP_STAGES - 1];
    assign o_out.overlap = r_overlap;

endmodule

// ----- test/tpo_overlap_checker.sv -----
// Checker for the triangle pair overlap unit: watches both channels, computes the
// expected overlap flag per accepted item and compares it.
// Depends on tpo_pkg.
module tpo_overlap_checker import tpo_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  logic [VW-1:0]  i_vtx [6],
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  logic           i_out_overlap,
    input  logic           i_cfg_we,
    input  logic [MGW-1:0] i_cfg_wdata,
    output int             o_errors,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0]  t_s64;
    typedef logic signed [159:0] t_big;

    logic [MGW-1:0] margin_q;
    bit             flags_q[$];

    // Signed slice of a vertex word; high z bits beyond the word read as zero
    function automatic t_s64 slice_of(input logic [VW-1:0] w, input int s);
        logic [191:0] ext;
        logic [CW-1:0] raw;
        ext = 192'(w);
        raw = ext[s*CW +: CW];
        return t_s64'(signed'(raw));
    endfunction

    // Does one axis separate the pair under the squared margin?
    function automatic bit axis_splits(input t_s64 ax[3], input t_s64 ta[3][3],
                                       input t_s64 tb[3][3], input t_big m2);
        t_big len2, p, lo_a, hi_a, lo_b, hi_b, g1, g2;
        len2 = 0;
        for (int k = 0; k < 3; k++) len2 += t_big'(ax[k]) * t_big'(ax[k]);
        for (int i = 0; i < 3; i++) begin
            p = t_big'(ta[i][0]) * ax[0] + t_big'(ta[i][1]) * ax[1]
                + t_big'(ta[i][2]) * ax[2];
            if (i == 0 || p < lo_a) lo_a = p;
            if (i == 0 || p > hi_a) hi_a = p;
            p = t_big'(tb[i][0]) * ax[0] + t_big'(tb[i][1]) * ax[1]
                + t_big'(tb[i][2]) * ax[2];
            if (i == 0 || p < lo_b) lo_b = p;
            if (i == 0 || p > hi_b) hi_b = p;
        end
        g1 = lo_b - hi_a;
        g2 = lo_a - hi_b;
        return (g1 > 0 && g1 * g1 > m2 * len2) || (g2 > 0 && g2 * g2 > m2 * len2);
    endfunction

    function automatic void cross3(input t_s64 p[3], input t_s64 q[3], output t_s64 r[3]);
        r[0] = p[1] * q[2] - p[2] * q[1];
        r[1] = p[2] * q[0] - p[0] * q[2];
        r[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    // Expected flag: 1 when none of the eleven axes separates
    function automatic bit predict_overlap(input logic [VW-1:0] v[6], input logic [MGW-1:0] m);
        t_s64 ta[3][3], tb[3][3], ea[3], eb[3], ax[3];
        t_big m2;
        bit sep;
        m2 = t_big'(m) * t_big'(m);
        sep = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                ta[i][j] = slice_of(v[i], j);
                tb[i][j] = slice_of(v[3+i], j);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    ea[k] = ta[i][k] - ta[(i+1)%3][k];
                    eb[k] = tb[j][k] - tb[(j+1)%3][k];
                end
                cross3(ea, eb, ax);
                sep |= axis_splits(ax, ta, tb, m2);
            end
        for (int k = 0; k < 3; k++) begin
            ea[k] = ta[1][k] - ta[0][k];
            eb[k] = ta[2][k] - ta[0][k];
        end
        cross3(ea, eb, ax);
        sep |= axis_splits(ax, ta, tb, m2);
        for (int k = 0; k < 3; k++) begin
            ea[k] = tb[1][k] - tb[0][k];
            eb[k] = tb[2][k] - tb[0][k];
        end
        cross3(ea, eb, ax);
        sep |= axis_splits(ax, ta, tb, m2);
        return !sep;
    endfunction

    assign o_pending = flags_q.size();

    // Track margin, queue predictions, compare results
    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            margin_q <= '0;
            flags_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) margin_q <= i_cfg_wdata;
            if (i_in_valid && i_in_ready) flags_q.push_back(predict_overlap(i_vtx, margin_q));
            if (i_out_valid && i_out_ready) begin
                if (flags_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result overlap=%0b", i_out_overlap);
                    o_errors <= o_errors + 1;
                end else begin
                    want = flags_q.pop_front();
                    if (want !== i_out_overlap) begin
                        if (o_errors < 10)
                            $display("overlap mismatch: expected %0b got %0b", want, i_out_overlap);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- test/tb_triangle_pair_overlap_sat_unit.sv -----
// Testbench top for the triangle pair overlap unit: clock, reset, margin writes,
// triangle pair stimulus and verdict. Depends on tpo_pkg, the channel interfaces and the checker.
module tb_triangle_pair_overlap_sat_unit;
    import tpo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [MGW-1:0] i_cfg_wdata = '0;
    logic [VW-1:0]  vtx [6];
    int             err_count, pending;
    int             in_gap_max = 14, out_gap_max = 14;
    int             out_wait;

    tpo_in_if  in_ch();
    tpo_out_if out_ch();

    triangle_pair_overlap_sat_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    assign vtx[0] = in_ch.a_vertex0;
    assign vtx[1] = in_ch.a_vertex1;
    assign vtx[2] = in_ch.a_vertex2;
    assign vtx[3] = in_ch.b_vertex0;
    assign vtx[4] = in_ch.b_vertex1;
    assign vtx[5] = in_ch.b_vertex2;

    tpo_overlap_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_vtx(vtx), .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_out_overlap(out_ch.overlap), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(err_count), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    // Pack three signed coordinates into a vertex word
    function automatic logic [VW-1:0] pack_vertex(input int x, input int y, input int z);
        return {CW'(z), CW'(y), CW'(x)};
    endfunction

    // Coordinate near a center with a spread, sometimes a full-range value
    function automatic int draw_coord(input int ctr, input int spread);
        if ($urandom_range(0, 15) == 0) return int'(signed'(CW'($urandom())));
        return ctr + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Offer one triangle pair and hold it until accepted; drop valid only while idling
    task automatic send_pair(input logic [VW-1:0] v[6]);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.a_vertex0 <= v[0]; in_ch.a_vertex1 <= v[1]; in_ch.a_vertex2 <= v[2];
        in_ch.b_vertex0 <= v[3]; in_ch.b_vertex1 <= v[4]; in_ch.b_vertex2 <= v[5];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Random pair; mostly neighbors so both verdicts show up
    task automatic send_random_pair();
        logic [VW-1:0] v[6];
        int spread, cx, cy, cz, off;
        spread = 1 << $urandom_range(4, 18);
        cx = draw_coord(0, 200000); cy = draw_coord(0, 200000); cz = draw_coord(0, 200000);
        off = $urandom_range(0, 3) == 0 ? 0 : spread;
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 7) == 0) v[i] = VW'({$urandom(), $urandom()});
            else if (i < 3) v[i] = pack_vertex(draw_coord(cx, spread), draw_coord(cy, spread),
                                                draw_coord(cz, spread));
            else v[i] = pack_vertex(draw_coord(cx + off, spread), draw_coord(cy, spread),
                                    draw_coord(cz, spread));
        end
        send_pair(v);
    endtask

    // Write the margin while the block is idle
    task automatic write_margin(input logic [MGW-1:0] m);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (TOP_STAGES + 2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: draw a wait for every item, then hold ready high until it is taken
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            w = $urandom_range(0, out_gap_max);
            out_wait <= w;
            out_ch.ready <= (w == 0);
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            out_ch.ready <= (out_wait == 1);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        logic [VW-1:0] v[6];
        int q, lim;
        in_ch.valid = 1'b0;
        in_ch.a_vertex0 = '0; in_ch.a_vertex1 = '0; in_ch.a_vertex2 = '0;
        in_ch.b_vertex0 = '0; in_ch.b_vertex1 = '0; in_ch.b_vertex2 = '0;
        lim = (1 << (CW - 1)) - 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, degenerate, touching, clearly apart
        foreach (v[i]) v[i] = '0;
        send_pair(v);
        foreach (v[i]) v[i] = '1;
        send_pair(v);
        v[0] = pack_vertex(lim, lim, lim); v[1] = pack_vertex(-lim-1, lim, -lim-1);
        v[2] = pack_vertex(lim, -lim-1, -lim-1);
        v[3] = pack_vertex(-lim-1, -lim-1, lim); v[4] = pack_vertex(lim, -lim-1, lim);
        v[5] = pack_vertex(-lim-1, lim, lim);
        send_pair(v);
        q = 4096;
        v[0] = pack_vertex(0, 0, 0); v[1] = pack_vertex(q, 0, 0); v[2] = pack_vertex(0, q, 0);
        v[3] = pack_vertex(0, 0, q); v[4] = pack_vertex(q, 0, q); v[5] = pack_vertex(0, q, q);
        send_pair(v);
        v[3] = pack_vertex(0, 0, 0); v[4] = pack_vertex(q, 0, 2*q); v[5] = pack_vertex(0, q, q);
        send_pair(v);
        v[3] = pack_vertex(0, 0, q+1); v[4] = pack_vertex(q, 0, q+1); v[5] = pack_vertex(0, q, q+1);
        send_pair(v);
        v[3] = pack_vertex(5*q, 5*q, 5*q); v[4] = pack_vertex(5*q, 5*q, 5*q);
        v[5] = pack_vertex(5*q, 5*q, 5*q);
        send_pair(v);
        v[0] = pack_vertex(0, 0, 0); v[1] = pack_vertex(0, 0, 0); v[2] = pack_vertex(0, 0, 0);
        send_pair(v);

        // Margin phases, extremes included; a small margin bridges the two-lsb gap
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_margin('0);
                1: write_margin('1);
                2: write_margin(MGW'(1));
                3: write_margin(MGW'(4096));
                default: write_margin(MGW'($urandom_range(0, 1 << (MGW - 1))));
            endcase
            in_gap_max = (ph % 2) ? 0 : 14;
            out_gap_max = (ph == 3) ? 0 : 14;
            v[0] = pack_vertex(0, 0, 0); v[1] = pack_vertex(q, 0, 0);
            v[2] = pack_vertex(0, q, 0);
            v[3] = pack_vertex(0, 0, 2); v[4] = pack_vertex(q, 0, 2); v[5] = pack_vertex(0, q, 2);
            send_pair(v);
            repeat (100) send_random_pair();
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (TOP_STAGES + 5) @(posedge i_clk);
        if (err_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
